@@ rtl/line_pixel_stepper_assert.svh @@
// ---------------------------------------------------------------------------
// line_pixel_stepper assertion macros
// Shared helpers for the concurrent checks of the line stepper RTL.
// ---------------------------------------------------------------------------
`ifndef LINE_PIXEL_STEPPER_ASSERT_SVH
`define LINE_PIXEL_STEPPER_ASSERT_SVH

// same-cycle implication, checked on every rising edge out of reset
`define LPS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line_pixel_stepper check failed");

// next-cycle implication, checked on every rising edge out of reset
`define LPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line_pixel_stepper check failed");

`endif

@@ rtl/lps_pkg.sv @@
// ---------------------------------------------------------------------------
// lps_pkg
// Constants and codes shared by the line pixel stepper modules.
// ---------------------------------------------------------------------------
package lps_pkg;

    // coordinate width default
    localparam int COORD_BITS_DEF = 10;

    // screen size registers
    localparam int SCREEN_BITS = 11;
    localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RST  = 11'd480;
    localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RST = 11'd272;

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 1'b1;

    // command codes carried in tuser
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // line modes
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_VERT  = 2'd1;
    localparam logic [1:0] MODE_HORZ  = 2'd2;
    localparam logic [1:0] MODE_SLOPE = 2'd3;

endpackage

@@ rtl/lps_mul.sv @@
// ---------------------------------------------------------------------------
// lps_mul
// Bit-serial unsigned multiplier, multiplier bits taken MSB first.
// ---------------------------------------------------------------------------
module lps_mul #(
    parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [COORD_BITS-1:0]     multiplicand,
    input  logic [COORD_BITS-1:0]     multiplier,
    output logic                      done,
    output logic [2*COORD_BITS-1:0]   product
);

    localparam int PROD_W = 2 * COORD_BITS;
    localparam int CNT_W  = $clog2(COORD_BITS + 1);

    logic [CNT_W-1:0]      cnt_reg;
    logic                  done_reg;
    logic [PROD_W-1:0]     acc_reg;
    logic [COORD_BITS-1:0] mplr_reg;
    logic [COORD_BITS-1:0] mcand_reg;
    logic [PROD_W-1:0]     acc_next;

    // Horner step: double and add the multiplicand on a one bit
    assign acc_next = {acc_reg[PROD_W-2:0], 1'b0}
                    + (mplr_reg[COORD_BITS-1] ? PROD_W'(mcand_reg) : PROD_W'(0));

    // bit counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(COORD_BITS);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // operand shift register and accumulator
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg   <= '0;
            mplr_reg  <= multiplier;
            mcand_reg <= multiplicand;
        end
        else if (cnt_reg != '0)
        begin
            acc_reg  <= acc_next;
            mplr_reg <= {mplr_reg[COORD_BITS-2:0], 1'b0};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

@@ rtl/lps_div.sv @@
// ---------------------------------------------------------------------------
// lps_div
// Restoring bit-serial divider, one quotient bit per cycle.
// The caller guarantees the quotient fits in COORD_BITS bits.
// ---------------------------------------------------------------------------
module lps_div #(
    parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [2*COORD_BITS-1:0]   dividend,
    input  logic [COORD_BITS-1:0]     divisor,
    output logic                      done,
    output logic [COORD_BITS-1:0]     quotient
);

    localparam int CNT_W = $clog2(COORD_BITS + 1);

    logic [CNT_W-1:0]      cnt_reg;
    logic                  done_reg;
    logic [COORD_BITS-1:0] rem_reg;
    logic [COORD_BITS-1:0] quo_reg;
    logic [COORD_BITS-1:0] dvs_reg;
    logic [COORD_BITS:0]   shifted;
    logic [COORD_BITS:0]   diff;
    logic                  fits;
    logic [COORD_BITS-1:0] rem_next;

    // trial subtract of the divisor from the shifted remainder
    assign shifted  = {rem_reg, quo_reg[COORD_BITS-1]};
    assign fits     = (shifted >= {1'b0, dvs_reg});
    assign diff     = shifted - {1'b0, dvs_reg};
    assign rem_next = fits ? diff[COORD_BITS-1:0] : shifted[COORD_BITS-1:0];

    // bit counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(COORD_BITS);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // low dividend bits shift out as quotient bits shift in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[2*COORD_BITS-1:COORD_BITS];
            quo_reg <= dividend[COORD_BITS-1:0];
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[COORD_BITS-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/line_pixel_stepper.sv @@
// ---------------------------------------------------------------------------
// line_pixel_stepper
// Steps through the pixels of a straight line, one pixel per step item.
// ---------------------------------------------------------------------------
// Usage:
//   Input items on s_tvalid/s_tready/s_tdata/s_tuser; tuser picks a start item
//   (latches both endpoints, no result) or a step item (next pixel, or nothing
//   when no line is active). Results on m_tvalid/m_tready/m_tdata/m_tuser/m_tlast:
//   tlast marks the final pixel, tuser the in-bounds flag. Screen size is written
//   on cfg_valid/cfg_index/cfg_data while idle by the user; the block does not enforce it.
// Sequencing:
//   Sloped start: the serial multiplier forms the first row numerator.
//   Sloped step: the serial divider forms the row (one row bit per cycle), then
//   the pixel goes through the put state into the output register.
//   Vertical and horizontal steps go straight to the put state; others give no pixel.
//   One item is worked on at a time; s_tready is high only between items.
// Reset: no line active, screen 480 x 272, no result pending.
// Stall: a finished result waits in the output register; items are still taken
//   until a new pixel is ready, then that pixel and all input wait until it is free.
// ---------------------------------------------------------------------------
module line_pixel_stepper #(
    parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF,
    localparam int IN_DATA_W  = ((4 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_W = ((2 * COORD_BITS + 1 + 7) / 8) * 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input items
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [IN_DATA_W-1:0]                 s_tdata,  // start_x, start_y, end_x, end_y
    input  logic                                 s_tuser,  // cmd
    // result items
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [OUT_DATA_W-1:0]                m_tdata,  // pixel_x, pixel_y
    output logic                                 m_tuser,  // in_bounds
    output logic                                 m_tlast,  // last_pixel
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lps_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [lps_pkg::SCREEN_BITS-1:0]      cfg_data
);

    import lps_pkg::*;

    `include "line_pixel_stepper_assert.svh"

    localparam int CB     = COORD_BITS;
    localparam int NUM_W  = 2 * COORD_BITS;
    localparam int CMP_W  = (CB + 1 > SCREEN_BITS) ? CB + 1 : SCREEN_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_PUT  = 2'd3;

    logic [1:0]             state_reg;
    logic [1:0]             state_next;
    logic [1:0]             mode_reg;
    logic [CB-1:0]          cur_reg;
    logic [CB-1:0]          stop_reg;
    logic [CB-1:0]          fixed_reg;
    logic [CB-1:0]          span_reg;
    logic [CB:0]            dyl_reg;
    logic [NUM_W-1:0]       num_reg;
    logic [SCREEN_BITS-1:0] width_reg;
    logic [SCREEN_BITS-1:0] height_reg;

    logic                   m_valid_reg;
    logic [CB-1:0]          px_out_reg;
    logic [CB:0]            py_out_reg;
    logic                   inb_reg;
    logic                   last_reg;

    logic [CB-1:0]          x0;
    logic [CB-1:0]          y0;
    logic [CB-1:0]          x1;
    logic [CB-1:0]          y1;
    logic                   s_accept;
    logic                   is_start;
    logic                   is_sloped;
    logic                   x_lt;
    logic [CB-1:0]          span_in;
    logic [CB-1:0]          ymin_in;
    logic [CB:0]            dyl_in;
    logic                   mul_start;
    logic                   mul_done;
    logic [NUM_W-1:0]       mul_product;
    logic                   div_start;
    logic                   div_done;
    logic [CB-1:0]          div_quotient;
    logic                   out_free;
    logic                   put_fire;
    logic                   last_now;
    logic [CB-1:0]          col_now;
    logic [CB:0]            row_now;
    logic                   inb_now;

    // unpack the endpoint fields
    assign x0 = s_tdata[CB-1:0];
    assign y0 = s_tdata[2*CB-1:CB];
    assign x1 = s_tdata[3*CB-1:2*CB];
    assign y1 = s_tdata[4*CB-1:3*CB];

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign is_start  = (s_tuser == CMD_START);
    assign is_sloped = (x0 != x1) && (y0 != y1);

    // sloped line seen from its left end: y = (yleft*span + dyl*t) / span
    assign x_lt    = (x0 < x1);
    assign span_in = x_lt ? (x1 - x0) : (x0 - x1);
    assign ymin_in = x_lt ? y0 : y1;
    assign dyl_in  = x_lt ? ({1'b0, y1} - {1'b0, y0}) : ({1'b0, y0} - {1'b0, y1});

    assign mul_start = s_accept && is_start && is_sloped;
    assign div_start = s_accept && !is_start && (mode_reg == MODE_SLOPE);

    // first numerator, left-end y times span
    lps_mul #(
        .COORD_BITS (COORD_BITS)
    ) u_mul (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (mul_start),
        .multiplicand (ymin_in),
        .multiplier   (span_in),
        .done         (mul_done),
        .product      (mul_product)
    );

    // row of the current column
    lps_div #(
        .COORD_BITS (COORD_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_reg),
        .divisor  (span_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // pixel being emitted
    assign out_free = !m_valid_reg || m_tready;
    assign put_fire = (state_reg == ST_PUT) && out_free;
    assign last_now = (cur_reg == stop_reg);
    assign col_now  = (mode_reg == MODE_VERT) ? fixed_reg : cur_reg;

    always_comb
    begin
        case (mode_reg)
            MODE_VERT:  row_now = {1'b0, cur_reg};
            MODE_HORZ:  row_now = {1'b0, fixed_reg};
            default:    row_now = {1'b0, div_quotient};
        endcase
    end

    assign inb_now = (CMP_W'(col_now) < CMP_W'(width_reg))
                  && !row_now[CB]
                  && (CMP_W'(row_now[CB-1:0]) < CMP_W'(height_reg));

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    if (is_start)
                        state_next = is_sloped ? ST_MUL : ST_IDLE;
                    else if (mode_reg == MODE_SLOPE)
                        state_next = ST_DIV;
                    else if (mode_reg != MODE_IDLE)
                        state_next = ST_PUT;
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                    state_next = ST_IDLE;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_PUT;
            end
            ST_PUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            cur_reg   <= '0;
            stop_reg  <= '0;
            fixed_reg <= '0;
            span_reg  <= '0;
            dyl_reg   <= '0;
            num_reg   <= '0;
        end
        else if (s_accept && is_start)
        begin
            span_reg <= span_in;
            dyl_reg  <= dyl_in;
            if (x0 == x1)
            begin
                fixed_reg <= x0;
                cur_reg   <= y0;
                stop_reg  <= y1 - 1'b1;
                mode_reg  <= (y0 < y1) ? MODE_VERT : MODE_IDLE;
            end
            else if (y0 == y1)
            begin
                fixed_reg <= y0;
                cur_reg   <= x0;
                stop_reg  <= x1 - 1'b1;
                mode_reg  <= (x0 < x1) ? MODE_HORZ : MODE_IDLE;
            end
            else
            begin
                fixed_reg <= '0;
                cur_reg   <= x_lt ? x0 : x1;
                stop_reg  <= x_lt ? x1 : x0;
                mode_reg  <= MODE_SLOPE;
            end
        end
        else if ((state_reg == ST_MUL) && mul_done)
        begin
            num_reg <= mul_product;
        end
        else if (put_fire)
        begin
            if (last_now)
            begin
                mode_reg <= MODE_IDLE;
            end
            else
            begin
                cur_reg <= cur_reg + 1'b1;
                num_reg <= num_reg + {{(NUM_W-CB-1){dyl_reg[CB]}}, dyl_reg};
            end
        end
    end

    // screen size registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SCREEN_WIDTH_RST;
            height_reg <= SCREEN_HEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                REG_SCREEN_HEIGHT: height_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (put_fire)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (put_fire)
        begin
            px_out_reg <= col_now;
            py_out_reg <= row_now;
            inb_reg    <= inb_now;
            last_reg   <= last_now;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_DATA_W'({py_out_reg, px_out_reg});
    assign m_tuser  = inb_reg;
    assign m_tlast  = last_reg;

    // checks
    `LPS_ASSERT_NEXT(a_put_loads_out, put_fire, m_valid_reg)
    `LPS_ASSERT_IMPL(a_div_only_sloped, state_reg == ST_DIV, mode_reg == MODE_SLOPE)
    `LPS_ASSERT_IMPL(a_cur_not_past_stop, mode_reg != MODE_IDLE, cur_reg <= stop_reg)
    `LPS_ASSERT_NEXT(a_last_goes_idle, put_fire && last_now, mode_reg == MODE_IDLE)

endmodule
